/* src/fwm_pkg.sv */
// ----------------------------------------------------------------------------
// fwm_pkg
// Shared widths, constants and types of the frame rate window meter.
// ----------------------------------------------------------------------------
package fwm_pkg;

  localparam int TIME_W              = 32;
  localparam int FPS_W               = 10;
  localparam int QUOT_W              = 10;
  localparam int OUT_TDATA_W         = 16;
  localparam int MS_PER_SECOND       = 1000;
  localparam int IDLE_RATE_RESET     = 60;
  localparam int WINDOW_SIZE_DEFAULT = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/fwm_serial_div.sv */
// ----------------------------------------------------------------------------
// fwm_serial_div
// Restoring divider, one quotient bit per cycle, ten-bit quotient.
// ----------------------------------------------------------------------------
module fwm_serial_div #(
  parameter int DVW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DVW-1:0]                init_rem,
  input  logic [fwm_pkg::QUOT_W-1:0]    init_low,
  input  logic [DVW-1:0]                divisor,
  output logic [fwm_pkg::QUOT_W-1:0]    quotient,
  output fwm_pkg::div_stat_t            stat
);
  import fwm_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [DVW-1:0]    rem;
  logic [DVW-1:0]    dvs;
  logic [QUOT_W-1:0] low;
  logic [CNT_W-1:0]  cnt;
  logic [DVW:0]      trial;
  logic              fits;

  assign trial = {rem, low[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == CNT_W'(QUOT_W - 1));
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= init_rem;
      low      <= init_low;
      dvs      <= divisor;
      quotient <= '0;
    end else if (stat.busy) begin
      low      <= {low[QUOT_W-2:0], 1'b0};
      quotient <= {quotient[QUOT_W-2:0], fits};
      if (fits) begin
        rem <= DVW'(trial - {1'b0, dvs});
      end else begin
        rem <= DVW'(trial);
      end
    end
  end

endmodule

/* src/fwm_ring.sv */
// ----------------------------------------------------------------------------
// fwm_ring
// Interval ring with per-entry valid bits and the running window sum.
// ----------------------------------------------------------------------------
module fwm_ring #(
  parameter int WINDOW_SIZE = fwm_pkg::WINDOW_SIZE_DEFAULT
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             rd_en,
  input  logic                                             wr_en,
  input  logic [fwm_pkg::TIME_W-1:0]                       gap,
  output logic [fwm_pkg::TIME_W+$clog2(WINDOW_SIZE)-1:0]   sum
);
  import fwm_pkg::*;

  localparam int PW    = $clog2(WINDOW_SIZE);
  localparam int SUM_W = TIME_W + PW;

  logic [TIME_W-1:0]      mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] vld;
  logic [PW-1:0]          pos;
  logic [TIME_W-1:0]      old_word;
  logic                   old_vld;
  logic [TIME_W-1:0]      old_val;

  assign old_val = old_vld ? old_word : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      old_word <= mem[pos];
    end
    if (wr_en) begin
      mem[pos] <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      pos     <= '0;
      sum     <= '0;
      old_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        old_vld <= vld[pos];
      end
      if (wr_en) begin
        vld[pos] <= 1'b1;
        sum      <= sum - SUM_W'(old_val) + SUM_W'(gap);
        if (pos == PW'(WINDOW_SIZE - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

/* src/frame_rate_window_meter_unit.sv */
// ----------------------------------------------------------------------------
// frame_rate_window_meter_unit
// Moving-average frame rate meter over a ring of frame intervals.
//
//   channel   direction  payload
//   s_axis    in         tdata[31:0] current_time
//   m_axis    out        tdata[9:0]  frames_per_second
//   cfg       in         data[9:0]   idle_rate
//
// One word in flight; from accept a word passes the sum update, the range
// check, two passes of the shared one-bit-per-cycle divider (average, then
// rate) and the load of the output register.
// A zero average or a zero rate skips the divider.
// Reset is synchronous; ring entries read as zero until written.
// A stalled result holds in the output register; the next word is taken
// while it waits.
// ----------------------------------------------------------------------------
module frame_rate_window_meter_unit #(
  parameter int WINDOW_SIZE = fwm_pkg::WINDOW_SIZE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fwm_pkg::TIME_W-1:0]           s_axis_tdata,   // [31:0] current_time
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fwm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [9:0] frames_per_second
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fwm_pkg::FPS_W-1:0]            cfg_data        // [9:0] idle_rate
);
  import fwm_pkg::*;

  localparam int PW        = $clog2(WINDOW_SIZE);
  localparam int SUM_W     = TIME_W + PW;
  localparam int DVW       = (PW + 1 > QUOT_W) ? PW + 1 : QUOT_W;
  localparam int SAT_LIMIT = (MS_PER_SECOND + 1) * WINDOW_SIZE;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_CHECK = 6'b000100,
    S_AVG   = 6'b001000,
    S_FPS   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state;
  logic [FPS_W-1:0]   idle_rate;
  logic [TIME_W-1:0]  prev_time;
  logic               seen_first;
  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  diff;
  logic [SUM_W-1:0]   sum;
  logic [FPS_W-1:0]   fps;
  logic               accept;
  logic               out_load;
  logic               div_start;
  logic [DVW-1:0]     div_init_rem;
  logic [QUOT_W-1:0]  div_init_low;
  logic [DVW-1:0]     div_divisor;
  logic [QUOT_W-1:0]  div_quot;
  div_stat_t          div_stat;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign cfg_ready     = 1'b1;
  assign diff          = s_axis_tdata - prev_time;

  fwm_ring #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .rd_en(accept),
    .wr_en(state == S_SUM),
    .gap  (gap),
    .sum  (sum)
  );

  always_comb begin
    div_start    = 1'b0;
    div_init_rem = DVW'(sum >> QUOT_W);
    div_init_low = sum[QUOT_W-1:0];
    div_divisor  = DVW'(WINDOW_SIZE);
    unique case (state)
      S_CHECK: begin
        div_start = (sum >= SUM_W'(WINDOW_SIZE)) && (sum < SUM_W'(SAT_LIMIT));
      end
      S_AVG: begin
        div_start    = div_stat.done;
        div_init_rem = '0;
        div_init_low = QUOT_W'(MS_PER_SECOND);
        div_divisor  = DVW'(div_quot);
      end
      default: begin
      end
    endcase
  end

  fwm_serial_div #(
    .DVW(DVW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .init_rem(div_init_rem),
    .init_low(div_init_low),
    .divisor (div_divisor),
    .quotient(div_quot),
    .stat    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idle_rate     <= FPS_W'(IDLE_RATE_RESET);
      prev_time     <= '0;
      seen_first    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_rate <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev_time  <= s_axis_tdata;
            seen_first <= 1'b1;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (div_start) begin
            state <= S_AVG;
          end else begin
            state <= S_DONE;
          end
        end
        S_AVG: begin
          if (div_stat.done) begin
            state <= S_FPS;
          end
        end
        S_FPS: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!seen_first || diff == '0) begin
        gap <= TIME_W'(1);
      end else begin
        gap <= diff;
      end
    end
    if (state == S_CHECK) begin
      if (sum < SUM_W'(WINDOW_SIZE)) begin
        fps <= idle_rate;
      end else begin
        fps <= '0;
      end
    end
    if (state == S_FPS && div_stat.done) begin
      fps <= div_quot;
    end
    if (out_load) begin
      m_axis_tdata <= OUT_TDATA_W'(fps);
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("word accepted while another is in flight");

  a_div_in_window: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_AVG || state == S_FPS))
    else $error("divider running outside a divide phase");

  a_avg_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_AVG && div_stat.done) |-> (div_quot != '0))
    else $error("zero average fed to rate divide");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=>
      (m_axis_tdata[FPS_W-1:0] <= FPS_W'(MS_PER_SECOND)) ||
      (m_axis_tdata[FPS_W-1:0] == $past(idle_rate)))
    else $error("rate out of range");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_rate_window_meter_unit. A scoreboard class
// keeps its own 32-entry interval ring, running sum and target rate, and
// predicts the rate for every accepted timestamp word. A directed phase walks
// the target register through its extremes while the window is still filling.
// It also covers the first frame, equal stamps, counter wrap and stamps that
// go backwards. Random bursts of frame timing follow under random stalls on
// both streams.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import fwm_pkg::*;

  localparam int WINDOW      = WINDOW_SIZE_DEFAULT;
  localparam int LATENCY     = 30;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 575;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {
    BURST_STEADY,
    BURST_JITTER,
    BURST_FAST,
    BURST_BACKWARD,
    BURST_WILD,
    BURST_SLOW
  } burst_kind_t;

  class fps_scoreboard_t;
    logic [TIME_W-1:0] ring [WINDOW];
    int unsigned       slot;
    logic [63:0]       window_sum;
    logic [TIME_W-1:0] last_stamp;
    bit                seen_first;
    logic [FPS_W-1:0]  target;
    logic [FPS_W-1:0]  expected_rates [$];
    int                errors;

    function new();
      foreach (ring[k]) ring[k] = '0;
      slot       = 0;
      window_sum = '0;
      last_stamp = '0;
      seen_first = 0;
      target     = FPS_W'(IDLE_RATE_RESET);
      errors     = 0;
    endfunction

    function void set_target(logic [FPS_W-1:0] value);
      target = value;
    endfunction

    function void note_frame(logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] gap;
      logic [63:0]       average;
      logic [FPS_W-1:0]  rate;
      if (!seen_first) begin
        gap        = 1;
        seen_first = 1;
      end else begin
        gap = stamp - last_stamp;
        if (gap == 0) gap = 1;
      end
      last_stamp = stamp;
      window_sum = window_sum - 64'(ring[slot]) + 64'(gap);
      ring[slot] = gap;
      slot       = (slot + 1) % WINDOW;
      average    = window_sum / 64'(WINDOW);
      if (average != 0) rate = FPS_W'(64'(MS_PER_SECOND) / average);
      else rate = target;
      expected_rates.push_back(rate);
    endfunction

    function void check_rate(logic [FPS_W-1:0] actual);
      logic [FPS_W-1:0] want;
      if (expected_rates.size() == 0) begin
        $display("%0t: unexpected rate word, expected none, actual %0d", $time, actual);
        errors++;
      end else begin
        want = expected_rates.pop_front();
        if (actual !== want) begin
          $display("%0t: frames_per_second mismatch, expected %0d, actual %0d",
                   $time, want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TIME_W-1:0]      s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [FPS_W-1:0]       cfg_data;

  fps_scoreboard_t   sb = new();
  int                cycle_count = 0;
  int                hold_req;
  logic [TIME_W-1:0] stamp_now;

  frame_rate_window_meter_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frame_rate_window_meter_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_rate(m_axis_tdata[FPS_W-1:0]);
  end

  // receiver: random stalls, calm stretches, and long holds on request
  initial begin
    int hold_seen;
    int stall_left;
    int calm_left;
    int r;
    hold_seen  = 0;
    stall_left = 0;
    calm_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          calm_left = $urandom_range(50, 300);
          m_axis_tready <= 1'b1;
        end else if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  task automatic send_frame(input logic [TIME_W-1:0] stamp);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_frame(stamp);
    stamp_now = stamp;
  endtask

  task automatic sender_gap(input bit calm);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (calm || r < 40) return;
    n = (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 80);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_target(input logic [FPS_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_target(value);
  endtask

  task automatic send_pair(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    send_frame(a);
    sender_gap(0);
    send_frame(b);
  endtask

  function automatic logic [TIME_W-1:0] next_stamp(input burst_kind_t kind,
                                                   input int base);
    unique case (kind)
      BURST_STEADY:   return stamp_now + TIME_W'(base + $urandom_range(0, 4)) - 2;
      BURST_JITTER:   return stamp_now + TIME_W'($urandom_range(0, 200));
      BURST_FAST:     return stamp_now + TIME_W'($urandom_range(0, 1));
      BURST_BACKWARD: return stamp_now - TIME_W'($urandom_range(1, 3));
      BURST_WILD:     return TIME_W'($urandom());
      default:        return stamp_now + TIME_W'($urandom_range(1000, 5000));
    endcase
  endfunction

  initial begin
    burst_kind_t kind;
    int          sent;
    int          burst_len;
    int          base;
    int          r;
    bit          calm;
    bit          held;
    bit          paused;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    hold_req      = 0;
    stamp_now     = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window still filling: unit gaps keep the average at zero
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_target(10'd0);
    send_pair(32'h0000_0000, 32'h0000_0000);
    write_target(10'd1023);
    send_pair(32'h0000_0001, 32'h0000_0002);
    write_target(10'd1);
    send_pair(32'h0000_0003, 32'h0000_0003);
    write_target(10'd1000);
    send_pair(32'h0000_0004, 32'h0000_0005);
    write_target(10'h2AA);
    send_pair(32'h0000_0006, 32'h0000_0006);
    write_target(10'h155);
    send_pair(32'h0000_0007, 32'h0000_0008);
    write_target(10'd60);

    // large forward jumps, backward steps and counter wrap
    send_frame(32'h5555_5555);
    sender_gap(0);
    send_frame(32'hAAAA_AAAA);
    sender_gap(0);
    send_frame(32'h0000_0000);
    sender_gap(0);
    send_frame(32'hFFFF_FFFF);
    sender_gap(0);
    send_frame(32'h0000_0000);
    sender_gap(0);
    send_frame(32'h0000_0010);

    sent   = 0;
    held   = 0;
    paused = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 40)      kind = BURST_STEADY;
      else if (r < 60) kind = BURST_JITTER;
      else if (r < 72) kind = BURST_FAST;
      else if (r < 82) kind = BURST_BACKWARD;
      else if (r < 92) kind = BURST_WILD;
      else             kind = BURST_SLOW;
      burst_len = $urandom_range(8, 40);
      base      = $urandom_range(2, 100);
      calm      = ($urandom_range(0, 4) == 0);
      repeat (burst_len) begin
        sender_gap(calm);
        send_frame(next_stamp(kind, base));
        sent++;
        if (!held && sent >= 200) begin
          held = 1;
          hold_req <= hold_req + 1;
        end
      end
      if (!paused && sent >= 400) begin
        paused = 1;
        write_target(10'($urandom_range(0, 1023)));
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("frame_rate_window_meter_unit test passed");
    end else begin
      $display("frame_rate_window_meter_unit test failed");
    end
    $finish;
  end

endmodule
